// File: hdl/cts_pkg.sv
// Shared types and fixed field widths for the cosh series block.
package cts_pkg;

    localparam int X_W        = 32;   // argument, signed Q3.F
    localparam int TOL_W      = 28;   // tolerance, Q0.F
    localparam int TERM_W     = 40;   // sum and terms, unsigned Q12.F
    localparam int IDX_W      = 7;    // stop index
    localparam int OUT_DATA_W = 88;   // sum + index + term, padded to bytes

    localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,     // waiting for an argument
        ST_SQR,      // squaring |x|
        ST_MUL_GO,   // launch term * xsq
        ST_TMUL,     // term * xsq in progress
        ST_TDIV,     // divide by (2k-1)(2k)
        ST_CHECK,    // stop test, sum update
        ST_DONE      // hand result to output register
    } cts_state_t;

endpackage

// File: hdl/cosh_taylor_series.sv
// Top level: cosh(x) by its Taylor series in fixed point, one shared multiplier and divider.
//
// Each argument x (signed Q3.F on s_tdata) produces one result item: the series sum
// 1 + x^2/2! + x^4/4! + ... in unsigned Q12.F (saturating at 2^40-1), the index k of
// the first term that is no more than 1.5 times the tolerance (that term is not added),
// the term itself, and a flag on m_tuser when MAX_TERMS terms ran out first (the last
// term is then added). The block takes one item at a time and drops s_tready while it
// works. The run time is set by the term loop: every term goes through the 40x16
// chunked multiplier (term * x^2) and then the 4-bit-per-cycle divider ((2k-1)(2k)),
// used back to back; the multiplier is also shared with the squaring of |x|. A finished
// result sits in an output register, so the next argument is accepted while it waits.
// The tolerance register (reset 2684) is written through cfg_valid/cfg_data. The user
// must write it only while idle; the block itself does not enforce this.
module cosh_taylor_series #(
    parameter int MAX_TERMS = 32,
    parameter int FRAC_BITS = 28
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cts_pkg::X_W-1:0]       s_tdata,   // [31:0] arg_x
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cts_pkg::OUT_DATA_W-1:0] m_tdata,  // [39:0] cosh_sum, [46:40] stop_index,
                                                     // [86:47] stop_term, [87] zero pad
    output logic                          m_tuser,   // [0] limit_hit
    // tolerance register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cts_pkg::TOL_W-1:0]     cfg_data
);
    import cts_pkg::*;

    // derived widths
    localparam int SQ_W   = 63 - FRAC_BITS;                 // |x|^2 >> F
    localparam int CW     = 16;                             // multiplier chunk
    localparam int BW_RAW = (SQ_W > X_W) ? SQ_W : X_W;
    localparam int BW     = ((BW_RAW + CW - 1) / CW) * CW;
    localparam int PW     = TERM_W + BW;
    localparam int NW     = TERM_W + SQ_W - FRAC_BITS;      // (term*xsq) >> F
    localparam int STEPS  = 4;
    localparam int QW     = ((NW + STEPS - 1) / STEPS) * STEPS;
    localparam int QX     = (QW > TERM_W) ? QW : TERM_W + 1;
    localparam int KW     = $clog2(MAX_TERMS + 1);
    localparam int DW     = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS - 1) + 1);
    localparam int THR_W  = TOL_W + 2;

    localparam logic [TERM_W-1:0] ONE_VAL =
        (FRAC_BITS >= TERM_W) ? TERM_MAX : TERM_W'(64'd1 << FRAC_BITS);

    cts_state_t state_reg, state_next;

    logic [TOL_W-1:0]  tol_reg;
    logic [SQ_W-1:0]   xsq_reg,  xsq_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [TERM_W-1:0] sum_reg,  sum_next;
    logic [KW-1:0]     k_reg,    k_next;
    logic              hit_reg,  hit_next;

    logic              m_tvalid_reg;
    logic [TERM_W-1:0] out_sum_reg, out_term_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_hit_reg;

    // handshakes and unit control
    logic              s_accept;
    logic              mul_start, mul_done;
    logic              div_start, div_done;
    logic              out_load;

    logic [X_W-1:0]    mag;
    logic [TERM_W-1:0] mul_a;
    logic [BW-1:0]     mul_b;
    logic [PW-1:0]     mul_p;
    logic [QW-1:0]     div_n;
    logic [DW-1:0]     div_d;
    logic [QW-1:0]     div_q;
    logic [QX-1:0]     q_x;
    logic [TERM_W-1:0] term_div;

    logic [KW:0]       two_k;
    logic [2*KW+1:0]   dprod;
    logic [THR_W-1:0]  thr3;
    logic              stop_hit;
    logic [TERM_W:0]   sum_wide;
    logic              last_k;

    assign s_accept = s_tvalid && s_tready;
    assign mag      = s_tdata[X_W-1] ? (~s_tdata + 1'b1) : s_tdata;

    // square |x| first, then term * xsq
    assign mul_a = (state_reg == ST_IDLE) ? TERM_W'(mag) : term_reg;
    assign mul_b = (state_reg == ST_IDLE) ? BW'(mag)     : BW'(xsq_reg);

    // divisor (2k-1)(2k)
    assign two_k = {k_reg, 1'b0};
    assign dprod = two_k * (two_k - 1'b1);
    assign div_d = DW'(dprod);
    assign div_n = QW'(mul_p >> FRAC_BITS);

    // saturate the quotient to 40 bits
    assign q_x      = QX'(div_q);
    assign term_div = ((q_x >> TERM_W) != '0) ? TERM_MAX : TERM_W'(q_x);

    // stop when 2*term <= 3*tol
    assign thr3     = THR_W'({tol_reg, 1'b0}) + THR_W'(tol_reg);
    assign stop_hit = {term_reg, 1'b0} <= (TERM_W + 1)'(thr3);
    assign sum_wide = {1'b0, sum_reg} + {1'b0, term_reg};
    assign last_k   = (k_reg == KW'(MAX_TERMS));

    cts_mul #(
        .AW (TERM_W),
        .BW (BW),
        .CW (CW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    cts_div #(
        .QW    (QW),
        .DW    (DW),
        .STEPS (STEPS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .n       (div_n),
        .d       (div_d),
        .done    (div_done),
        .q       (div_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_SQR;
            ST_SQR:    if (mul_done) state_next = ST_MUL_GO;
            ST_MUL_GO: state_next = ST_TMUL;
            ST_TMUL:   if (mul_done) state_next = ST_TDIV;
            ST_TDIV:   if (div_done) state_next = ST_CHECK;
            ST_CHECK: begin
                if (stop_hit || last_k) state_next = ST_DONE;
                else                    state_next = ST_MUL_GO;
            end
            ST_DONE:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                mul_start = s_tvalid;
            end
            ST_MUL_GO: mul_start = 1'b1;
            ST_TMUL:   div_start = mul_done;
            ST_DONE:   out_load  = !m_tvalid_reg || m_tready;
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        xsq_next  = xsq_reg;
        term_next = term_reg;
        sum_next  = sum_reg;
        k_next    = k_reg;
        hit_next  = hit_reg;
        case (state_reg)
            ST_IDLE: begin
                term_next = ONE_VAL;
                sum_next  = ONE_VAL;
                k_next    = KW'(1);
                hit_next  = 1'b0;
            end
            ST_SQR: begin
                if (mul_done) xsq_next = SQ_W'(mul_p >> FRAC_BITS);
            end
            ST_TDIV: begin
                if (div_done) term_next = term_div;
            end
            ST_CHECK: begin
                if (!stop_hit) begin
                    sum_next = sum_wide[TERM_W] ? TERM_MAX : sum_wide[TERM_W-1:0];
                    if (last_k) hit_next = 1'b1;
                    else        k_next   = k_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tol_reg      <= TOL_W'(2684);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) tol_reg <= cfg_data;
            if (out_load)               m_tvalid_reg <= 1'b1;
            else if (m_tready)          m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        xsq_reg  <= xsq_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        k_reg    <= k_next;
        hit_reg  <= hit_next;
        if (out_load) begin
            out_sum_reg  <= sum_reg;
            out_term_reg <= term_reg;
            out_idx_reg  <= IDX_W'(k_reg);
            out_hit_reg  <= hit_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(OUT_DATA_W - 2 * TERM_W - IDX_W){1'b0}},
                        out_term_reg, out_idx_reg, out_sum_reg};
    assign m_tuser   = out_hit_reg;

endmodule

// File: hdl/cts_mul.sv
// Sequential multiplier: A times B, one CW-bit chunk of B per cycle, MSB chunk first.
module cts_mul #(
    parameter int AW = 40,
    parameter int BW = 48,
    parameter int CW = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [AW-1:0]      a,
    input  logic [BW-1:0]      b,
    output logic               done,
    output logic [AW+BW-1:0]   p
);
    localparam int PW  = AW + BW;
    localparam int NCH = BW / CW;
    localparam int CNT_W = $clog2(NCH + 1);

    logic [AW-1:0]    a_reg;
    logic [BW-1:0]    b_reg;
    logic [PW-1:0]    acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [CW-1:0]    chunk;
    logic [AW+CW-1:0] pp;

    assign chunk = b_reg[BW-1 -: CW];
    assign pp    = a_reg * chunk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NCH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= (acc_reg << CW) + PW'(pp);
            b_reg   <= b_reg << CW;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// File: hdl/cts_div.sv
// Restoring divider, STEPS quotient bits per cycle, narrow divisor.
module cts_div #(
    parameter int QW    = 48,
    parameter int DW    = 12,
    parameter int STEPS = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [QW-1:0] n,
    input  logic [DW-1:0] d,
    output logic          done,
    output logic [QW-1:0] q
);
    localparam int NITER = QW / STEPS;
    localparam int CNT_W = $clog2(NITER + 1);

    logic [QW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [QW-1:0]    quo_step;
    logic [DW-1:0]    rem_step;

    // STEPS shift/compare/subtract stages on the narrow remainder
    always_comb begin
        logic [DW:0]   r2;
        logic [DW-1:0] r_v;
        logic [QW-1:0] q_v;
        logic          bit_v;
        r_v = rem_reg;
        q_v = quo_reg;
        for (int i = 0; i < STEPS; i++) begin
            r2 = {r_v, q_v[QW-1]};
            if (r2 >= {1'b0, d_reg}) begin
                bit_v = 1'b1;
                r_v   = DW'(r2 - {1'b0, d_reg});
            end else begin
                bit_v = 1'b0;
                r_v   = DW'(r2);
            end
            q_v = {q_v[QW-2:0], bit_v};
        end
        rem_step = r_v;
        quo_step = q_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NITER);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= n;
            rem_reg <= '0;
            d_reg   <= d;
        end else if (busy_reg) begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

    assign done = done_reg;
    assign q    = quo_reg;

endmodule

// File: tb/cosh_taylor_series_tb.sv
// Self-checking testbench for the fixed-point cosh Taylor series block.
module cosh_taylor_series_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    localparam int MAX_TERMS = 32;
    localparam int FRAC_BITS = 28;

    localparam logic [TOL_W-1:0] TOL_RESET = 28'd2684;
    localparam logic [TOL_W-1:0] TOL_MAX   = {TOL_W{1'b1}};

    // The tail wait covers one full run of the slowest item.
    localparam int DRAIN_CYCLES = 700;
    // Long receiver hold-off; the watchdog limit is several times hold + item.
    localparam int HOLD_CYCLES  = 2500;
    localparam int STALL_LIMIT  = 20000;

    typedef struct packed {
        logic [TERM_W-1:0] cosh_sum;
        logic [IDX_W-1:0]  stop_index;
        logic [TERM_W-1:0] stop_term;
        logic              limit_hit;
    } cosh_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [X_W-1:0]        s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [TOL_W-1:0]      cfg_data = '0;

    // Arguments waiting to be offered, and sums predicted for accepted ones.
    logic [X_W-1:0] pending_args[$];
    cosh_result_t   expected_sums[$];

    logic [TOL_W-1:0] tol_model;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    logic             hold_load = 1'b0;
    int               hold_left = 0;
    int               idle_cycles = 0;
    int               errors = 0;

    cosh_taylor_series #(
        .MAX_TERMS(MAX_TERMS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Series sum for one argument under a given tolerance. Every term is
    // floor(prev * xsq / ((2k-1)(2k) * 2^F)), done exactly in 128 bits and
    // clamped to 40 bits; the first term with 2*term <= 3*tol stops the run
    // and is left out of the sum.
    function automatic cosh_result_t cosh_series(input logic [X_W-1:0] x,
                                                 input logic [TOL_W-1:0] tol);
        cosh_result_t      res;
        logic [63:0]       mag;
        logic [63:0]       xsq;
        logic [127:0]      prod;
        logic [127:0]      wide_term;
        logic [127:0]      divisor;
        logic [127:0]      quo;
        logic [TERM_W-1:0] term;
        logic [TERM_W-1:0] sum;
        logic [TERM_W:0]   acc;
        logic [63:0]       twice_term;
        logic [63:0]       thr3;
        logic              done;
        int                denom;
        mag = x[X_W-1] ? {32'b0, -x} : {32'b0, x};
        xsq = (mag * mag) >> FRAC_BITS;
        term = TERM_W'(1) << FRAC_BITS;
        sum = term;
        thr3 = tol;
        thr3 = thr3 * 3;
        res.stop_index = IDX_W'(MAX_TERMS);
        res.stop_term = '0;
        res.limit_hit = 1'b1;
        done = 1'b0;
        for (int k = 1; k <= MAX_TERMS; k++) begin
            if (!done) begin
                denom = (2 * k - 1) * (2 * k);
                divisor = denom;
                divisor = divisor << FRAC_BITS;
                wide_term = term;
                prod = wide_term * xsq;
                quo = prod / divisor;
                term = (quo > TERM_MAX) ? TERM_MAX : quo[TERM_W-1:0];
                res.stop_term = term;
                twice_term = term;
                twice_term = twice_term << 1;
                if (twice_term <= thr3) begin
                    res.stop_index = k[IDX_W-1:0];
                    res.limit_hit = 1'b0;
                    done = 1'b1;
                end else begin
                    // cap reached or not, a failing term joins the sum
                    acc = {1'b0, sum} + {1'b0, term};
                    sum = acc[TERM_W] ? TERM_MAX : acc[TERM_W-1:0];
                end
            end
        end
        res.cosh_sum = sum;
        return res;
    endfunction

    // Mostly |x| <= 1.0 to keep the term loop short, some up to 4.0, a few
    // over the whole Q3.28 range (near 8.0 the loop runs longest).
    function automatic logic [X_W-1:0] random_arg();
        logic [X_W-1:0] v;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            v = $urandom_range(0, 32'h1000_0000);
        end else if (pick < 85) begin
            v = $urandom_range(0, 32'h4000_0000);
        end else begin
            return $urandom();
        end
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // Tolerance copy follows the write channel handshake.
    always @(posedge aclk) begin
        if (!aresetn) begin
            tol_model <= TOL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            tol_model <= cfg_data;
        end
    end

    // Driver: predict on acceptance, then offer the next pending argument
    // unless this cycle idles. valid is only ever assigned once per edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_sums.push_back(cosh_series(s_tdata, tol_model));
            if (!s_tvalid || s_tready) begin
                if (pending_args.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata  <= pending_args.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off counter for the receiver; loaded by a one-cycle request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_load) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare every result item against the oldest prediction.
    always @(posedge aclk) begin : result_check
        cosh_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    $error("result item with no prediction waiting");
                    errors++;
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tdata[0 +: TERM_W] !== want.cosh_sum) begin
                        $error("cosh_sum: expected %0h, got %0h",
                               want.cosh_sum, m_tdata[0 +: TERM_W]);
                        errors++;
                    end
                    if (m_tdata[TERM_W +: IDX_W] !== want.stop_index) begin
                        $error("stop_index: expected %0d, got %0d",
                               want.stop_index, m_tdata[TERM_W +: IDX_W]);
                        errors++;
                    end
                    if (m_tdata[TERM_W+IDX_W +: TERM_W] !== want.stop_term) begin
                        $error("stop_term: expected %0h, got %0h",
                               want.stop_term, m_tdata[TERM_W+IDX_W +: TERM_W]);
                        errors++;
                    end
                    if (m_tuser !== want.limit_hit) begin
                        $error("limit_hit: expected %0b, got %0b", want.limit_hit, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Tolerance write; only called with nothing in flight.
    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // Phase knobs and queue pushes change on the falling edge only.
    task automatic set_idling(input int send_pct, input int stall_pct);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_args.push_back(random_arg());
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_args.size() != 0 || s_tvalid || expected_sums.size() != 0);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset tolerance, no idling: directed corners of the argument.
        set_idling(0, 0);
        pending_args.push_back(32'h0000_0000);   // zero: first term is zero
        pending_args.push_back(32'h0000_0001);   // smallest positive
        pending_args.push_back(32'hFFFF_FFFF);   // smallest negative
        pending_args.push_back(32'h0000_4000);   // square is exactly one LSB
        pending_args.push_back(32'h0800_0000);   // 0.5
        pending_args.push_back(32'h1000_0000);   // 1.0
        pending_args.push_back(32'hF000_0000);   // -1.0
        pending_args.push_back(32'h2000_0000);   // 2.0
        pending_args.push_back(32'h3000_0000);   // 3.0
        pending_args.push_back(32'h4000_0000);   // 4.0
        pending_args.push_back(32'hC000_0000);   // -4.0
        pending_args.push_back(32'h5555_5555);
        pending_args.push_back(32'hAAAA_AAAA);
        pending_args.push_back(32'h7FFF_FFFF);   // largest positive
        pending_args.push_back(32'h8000_0000);   // most negative, |x| = 8.0
        pending_args.push_back(32'h8000_0001);
        wait_drained();

        // Zero tolerance: only a term that has decayed to zero stops the run.
        write_tolerance('0);
        set_idling(0, 0);
        pending_args.push_back(32'h0000_0000);
        pending_args.push_back(32'h1000_0000);
        pending_args.push_back(32'h7FFF_FFFF);
        pending_args.push_back(32'h8000_0000);
        queue_random(140);
        wait_drained();

        // Largest tolerance, sender idling.
        write_tolerance(TOL_MAX);
        set_idling(45, 0);
        pending_args.push_back(32'h7FFF_FFFF);
        pending_args.push_back(32'h0000_0000);
        queue_random(150);
        wait_drained();

        // Random tolerance, receiver stalling, plus one long hold-off while
        // the sender keeps offering so the block backs up into s_tready.
        write_tolerance($urandom_range(0, 32'h0FFF_FFFF));
        set_idling(0, 45);
        hold_load = 1'b1;
        queue_random(200);
        @(negedge aclk);
        hold_load = 1'b0;
        wait_drained();

        // Back to the reset value, both sides idling.
        write_tolerance(TOL_RESET);
        set_idling(29, 29);
        queue_random(200);
        wait_drained();

        // Small random tolerance; the sender pauses halfway until all
        // results are back, then carries on.
        write_tolerance($urandom_range(0, 100000));
        set_idling(29, 29);
        queue_random(120);
        wait_drained();
        queue_random(120);
        wait_drained();

        // Random tolerance, no idling at all.
        write_tolerance($urandom_range(0, 32'h0FFF_FFFF));
        set_idling(0, 0);
        queue_random(160);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_sums.size() != 0) begin
            $error("%0d predicted results never arrived", expected_sums.size());
            errors++;
        end
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
